FILE: sv/sphere_point_from_angles_core_macros.svh
// Assertion macros for the unit-sphere point core.
// Included by the top level; depends on nothing else.
`ifndef SPHERE_POINT_FROM_ANGLES_CORE_MACROS_SVH
`define SPHERE_POINT_FROM_ANGLES_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SPFA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spfa: implication check failed");
`define SPFA_ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) ((a) == (b))) \
    else $error("spfa: equality check failed");
`else
`define SPFA_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SPFA_ASSERT_SAME(label, clk, rst, a, b)
`endif
`endif

FILE: sv/spfa_pkg.sv
// Shared types and constants of the unit-sphere point core.
// Used by spfa_cordic and sphere_point_from_angles_core; depends on nothing.
package spfa_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_W         = OUT_FRAC_BITS + 2;

  // Phase word: 2^PHASE_W units make one full turn.
  localparam int PHASE_W       = 32;
  localparam int CORDIC_W      = 32;
  localparam int CORDIC_STAGES = 30;
  localparam int PROD_W        = 2 * CORDIC_W;

  // Stage registers, quadrant map register, product register, output register.
  localparam int LATENCY       = CORDIC_STAGES + 3;

  // Reciprocal of the CORDIC gain in Q.30.
  localparam logic signed [CORDIC_W-1:0] GAIN_INV = 32'sd652032874;

  // atan(2^-i) in units of 2^-32 turn.
  localparam logic signed [CORDIC_W-1:0] ATAN_TURNS [CORDIC_STAGES] = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
    32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
    32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2F9,
    32'sh0000517C, 32'sh000028BE, 32'sh0000145F, 32'sh00000A2F, 32'sh00000517,
    32'sh0000028B, 32'sh00000145, 32'sh000000A2, 32'sh00000051, 32'sh00000028,
    32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000002, 32'sh00000001
  };

  typedef struct packed {
    logic [ANGLE_BITS-1:0] u_angle;
    logic [ANGLE_BITS-1:0] v_angle;
  } spfa_angles_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] x_out;
    logic signed [OUT_W-1:0] y_out;
    logic signed [OUT_W-1:0] z_out;
    logic                    w_out;
  } spfa_point_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] cos_q;
    logic signed [CORDIC_W-1:0] sin_q;
  } spfa_sincos_t;

endpackage

FILE: sv/spfa_cordic.sv
// Pipelined rotation-mode CORDIC giving cosine and sine (Q.30) of a binary angle.
// Depends on spfa_pkg.
module spfa_cordic (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             valid_in,
  input  logic [spfa_pkg::ANGLE_BITS-1:0]  angle,
  output logic                             valid_out,
  output spfa_pkg::spfa_sincos_t           sincos
);

  localparam int N = spfa_pkg::CORDIC_STAGES;
  localparam int W = spfa_pkg::CORDIC_W;

  logic [spfa_pkg::PHASE_W-1:0] phase;
  logic signed [W-1:0]          x_s [N];
  logic signed [W-1:0]          y_s [N];
  logic signed [W-1:0]          z_s [N];
  logic [1:0]                   quad_s [N];
  logic                         vld_s [N];

  // The angle becomes a phase word; its top two bits are the quadrant.
  assign phase = {angle, {(spfa_pkg::PHASE_W - spfa_pkg::ANGLE_BITS){1'b0}}};

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [W-1:0] xin;
    logic signed [W-1:0] yin;
    logic signed [W-1:0] zin;
    logic [1:0]          qin;
    logic                vin;

    if (i == 0) begin : g_first
      assign xin = spfa_pkg::GAIN_INV;
      assign yin = '0;
      assign zin = W'(signed'({2'b00, phase[spfa_pkg::PHASE_W-3:0]}));
      assign qin = phase[spfa_pkg::PHASE_W-1 -: 2];
      assign vin = valid_in;
    end else begin : g_rest
      assign xin = x_s[i-1];
      assign yin = y_s[i-1];
      assign zin = z_s[i-1];
      assign qin = quad_s[i-1];
      assign vin = vld_s[i-1];
    end

    always_ff @(posedge clk) begin
      if (!zin[W-1]) begin
        x_s[i] <= xin - (yin >>> i);
        y_s[i] <= yin + (xin >>> i);
        z_s[i] <= zin - spfa_pkg::ATAN_TURNS[i];
      end else begin
        x_s[i] <= xin + (yin >>> i);
        y_s[i] <= yin - (xin >>> i);
        z_s[i] <= zin + spfa_pkg::ATAN_TURNS[i];
      end
      quad_s[i] <= qin;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[i] <= 1'b0;
      end else begin
        vld_s[i] <= vin;
      end
    end
  end

  // Unfold the quadrant into the final cosine and sine.
  always_ff @(posedge clk) begin
    unique case (quad_s[N-1])
      2'd0: begin
        sincos.cos_q <= x_s[N-1];
        sincos.sin_q <= y_s[N-1];
      end
      2'd1: begin
        sincos.cos_q <= -y_s[N-1];
        sincos.sin_q <= x_s[N-1];
      end
      2'd2: begin
        sincos.cos_q <= -x_s[N-1];
        sincos.sin_q <= -y_s[N-1];
      end
      default: begin
        sincos.cos_q <= y_s[N-1];
        sincos.sin_q <= -x_s[N-1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= vld_s[N-1];
    end
  end

endmodule

FILE: sv/sphere_point_from_angles_core.sv
// Top level of the unit-sphere point core: two CORDIC lanes, products, rounding.
// Depends on spfa_pkg, spfa_cordic and sphere_point_from_angles_core_macros.svh.
//
//   Channel   Handshake          Payload
//   -------   ----------------   -------------------------------------------
//   command   start / busy       angles : u_angle, v_angle (binary angles)
//   result    done (strobe)      point  : x_out, y_out, z_out (Q1.14), w_out
//
// One angle pair can be transferred in every clock cycle, and each one gives
// exactly one point after the thirty CORDIC stages, one quadrant register,
// the multiplier register and the rounding register. Busy is never raised,
// since the pipeline has no back-pressure: the receiver cannot stall, and
// the point is on the result ports for the single cycle that done marks.
// The synchronous reset clears only the valid bits that travel alongside
// the data.
`include "sphere_point_from_angles_core_macros.svh"

module sphere_point_from_angles_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  spfa_pkg::spfa_angles_t angles,
  output logic                   done,
  output spfa_pkg::spfa_point_t  point
);

  localparam int OUT_W      = spfa_pkg::OUT_W;
  localparam int PROD_W     = spfa_pkg::PROD_W;
  localparam int PROD_SHIFT = 2 * (spfa_pkg::CORDIC_W - 2) - spfa_pkg::OUT_FRAC_BITS;
  localparam int SIN_SHIFT  = (spfa_pkg::CORDIC_W - 2) - spfa_pkg::OUT_FRAC_BITS;
  localparam logic signed [PROD_W-1:0] ONE = PROD_W'(1) <<< spfa_pkg::OUT_FRAC_BITS;

  // Round half up by dropping sh fraction bits, then clamp to plus or minus one.
  function automatic logic signed [OUT_W-1:0] round_clamp(
    input logic signed [PROD_W-1:0] v,
    input int unsigned              sh
  );
    logic signed [PROD_W-1:0] half;
    logic signed [PROD_W-1:0] r;
    half = (sh == 0) ? '0 : (PROD_W'(1) <<< (sh - 1));
    r    = (v + half) >>> sh;
    if (r > ONE) begin
      r = ONE;
    end else if (r < -ONE) begin
      r = -ONE;
    end
    return r[OUT_W-1:0];
  endfunction

  logic                          u_valid;
  logic                          v_valid;
  spfa_pkg::spfa_sincos_t        sc_u;
  spfa_pkg::spfa_sincos_t        sc_v;
  logic signed [PROD_W-1:0]      prod_x;
  logic signed [PROD_W-1:0]      prod_y;
  logic signed [spfa_pkg::CORDIC_W-1:0] sin_v;
  logic                          prod_valid;

  // Every command is taken at once; the pipeline never holds off a transfer.
  assign busy = 1'b0;

  // The longitude and latitude lanes run in lockstep from the same start.
  spfa_cordic u_cordic_u (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (start),
    .angle     (angles.u_angle),
    .valid_out (u_valid),
    .sincos    (sc_u)
  );

  spfa_cordic u_cordic_v (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (start),
    .angle     (angles.v_angle),
    .valid_out (v_valid),
    .sincos    (sc_v)
  );

  // Product stage: exact Q.60 products, with the latitude sine carried along.
  // The operands are sign-extended to the product width before multiplying.
  always_ff @(posedge clk) begin
    prod_x <= PROD_W'(sc_v.cos_q) * PROD_W'(sc_u.cos_q);
    prod_y <= PROD_W'(sc_v.cos_q) * PROD_W'(sc_u.sin_q);
    sin_v  <= sc_v.sin_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= u_valid;
    end
  end

  // Output stage: rounding and saturation, after which the point is strobed.
  always_ff @(posedge clk) begin
    point.x_out <= round_clamp(prod_x, PROD_SHIFT);
    point.y_out <= round_clamp(prod_y, PROD_SHIFT);
    point.z_out <= round_clamp(PROD_W'(sin_v), SIN_SHIFT);
    point.w_out <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= prod_valid;
    end
  end

  // The two lanes must never drift apart.
  `SPFA_ASSERT_SAME(a_lanes_in_step, clk, rst, u_valid, v_valid)
  // A point only ever appears as the result of a transfer in, the full pipeline depth back.
  `SPFA_ASSERT_IMPLY(a_done_has_cause, clk, rst, done, $past(start, spfa_pkg::LATENCY))
  // A strobed point always has its height within the unit range and a weight of one.
  `SPFA_ASSERT_IMPLY(a_point_in_range, clk, rst, done,
    (point.z_out <= OUT_W'(ONE)) && (point.z_out >= -OUT_W'(ONE)) && point.w_out)

endmodule
